// ----- rtl/core/plo_pkg.sv -----
// Shared types, constants and helpers for the positional ordered list.
package plo_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_DUMP       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic [5:0]         length;
    logic               last;
  } rsp_t;

  // Work the sequencer has to do after a request is taken.
  typedef enum logic [2:0] {
    W_NONE,
    W_PLACE,
    W_SHIFT_UP,
    W_SHIFT_DN,
    W_DUMP
  } work_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_DUMP
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  count;
    work_t             work;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bound;
    logic [ADDR_W-1:0] raddr;
  } plan_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(logic [31:0] v);
    logic [63:0] t;
    t = {32'd0, v};
    return DATA_WIDTH'(t);
  endfunction

  function automatic logic [31:0] to_element(logic [DATA_WIDTH-1:0] w);
    logic [63:0] t;
    t = 64'(w);
    return t[31:0];
  endfunction

endpackage

// ----- rtl/core/positional_ordered_list.sv -----
// Positional ordered list: one list of words held front to back in a RAM.
//
// Requests arrive on req/req_valid/req_stall and carry an opcode, a value and
// a one-based position. Results leave on rsp/rsp_valid/rsp_stall. A request is
// taken when valid is high and stall is low; the same holds for results.
// Every request gives one result, except a dump of a non-empty list, which
// gives one result per held element, front to back, with last set on the
// final one.
// The result of any request but a dump sits in the output register in the
// cycle after the request is taken. Push back, pop back, clear and errors
// walk nothing; push front, insert, pop front and remove walk the RAM one
// entry per cycle through its single write port over the entries they move
// (a push front or insert that moves entries then writes the new value in a
// further step). A dump reads out one element per result, front to back.
// The next request is taken once that walk ends and the output register is
// free. While the receiver stalls, the output register holds and a dump
// pauses on the current entry.
// Reset empties the list; stored words are not cleared.
module positional_ordered_list (
  input  logic          clk,
  input  logic          rst,
  input  plo_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output plo_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import plo_pkg::*;

  plan_t                 plan;
  logic [CNT_W-1:0]      occ;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [DATA_WIDTH-1:0] rdata;

  plo_plan u_plan (
    .req  (req),
    .occ  (occ),
    .plan (plan)
  );

  plo_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .plan      (plan),
    .occ       (occ),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  plo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_len_tracks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.length == 6'(occ))
    else $error("result length differs from occupancy");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element == '0)
    else $error("error result not final or carries data");

endmodule

// ----- rtl/core/plo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/plo_plan.sv -----
// Request decode: status, new count and the memory work a request needs.
module plo_plan (
  input  plo_pkg::req_t                 req,
  input  logic [plo_pkg::CNT_W-1:0]     occ,
  output plo_pkg::plan_t                plan
);
  import plo_pkg::*;

  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] occ_c;
  logic [CMP_W-1:0] ins_c;
  logic [CMP_W-1:0] rem_c;

  always_comb begin
    full  = (occ == CNT_W'(CAPACITY));
    empty = (occ == '0);
    pos_c = CMP_W'(req.position);
    occ_c = CMP_W'(occ);

    case (req.opcode)
      OP_PUSH_FRONT: ins_c = '0;
      OP_PUSH_BACK:  ins_c = occ_c;
      default:       ins_c = pos_c - CMP_W'(1);
    endcase
    rem_c = (req.opcode == OP_POP_FRONT) ? '0 : pos_c - CMP_W'(1);

    plan        = '0;
    plan.status = ST_OK;
    plan.count  = occ;
    plan.work   = W_NONE;

    case (req.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (req.opcode == OP_INSERT &&
            (pos_c == '0 || pos_c > occ_c + CMP_W'(1))) begin
          plan.status = ST_BADPOS;
        end else if (full) begin
          plan.status = ST_FULL;
        end else begin
          plan.count = occ + CNT_W'(1);
          plan.start = ADDR_W'(occ);
          plan.bound = ADDR_W'(ins_c);
          if (ins_c == occ_c) begin
            plan.work = W_PLACE;
          end else begin
            // open a hole: move entries back starting from the tail
            plan.work  = W_SHIFT_UP;
            plan.raddr = ADDR_W'(occ_c - CMP_W'(1));
          end
        end
      end
      OP_POP_FRONT, OP_REMOVE: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else if (req.opcode == OP_REMOVE && (pos_c == '0 || pos_c > occ_c)) begin
          plan.status = ST_BADPOS;
        end else begin
          plan.count = occ - CNT_W'(1);
          if (rem_c != occ_c - CMP_W'(1)) begin
            // close the gap: move later entries forward
            plan.work  = W_SHIFT_DN;
            plan.start = ADDR_W'(rem_c);
            plan.bound = ADDR_W'(occ_c - CMP_W'(2));
            plan.raddr = ADDR_W'(rem_c + CMP_W'(1));
          end
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.count = occ - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        plan.count = '0;
      end
      OP_DUMP: begin
        if (empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.work = W_DUMP;
        end
      end
      default: begin
        plan.work = W_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/core/plo_seq.sv -----
// Sequencer: occupancy, memory shift and dump walks, output register.
module plo_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  plo_pkg::req_t                 req,
  input  logic                          req_valid,
  output logic                          req_stall,
  output plo_pkg::rsp_t                 rsp,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  plo_pkg::plan_t                plan,
  output logic [plo_pkg::CNT_W-1:0]     occ,
  output logic                          we,
  output logic [plo_pkg::ADDR_W-1:0]    waddr,
  output logic [plo_pkg::DATA_WIDTH-1:0] wdata,
  output logic [plo_pkg::ADDR_W-1:0]    raddr,
  input  logic [plo_pkg::DATA_WIDTH-1:0] rdata
);
  import plo_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [ADDR_W-1:0]     ptr;
  logic [ADDR_W-1:0]     bound;
  logic [DATA_WIDTH-1:0] hold;
  logic                  out_free;
  logic                  accept;
  logic                  up_last;
  logic                  dn_last;
  logic                  dump_last;
  logic                  load;
  rsp_t                  rsp_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == S_IDLE && out_free);
  assign accept    = req_valid && !req_stall;
  assign up_last   = (ptr == bound + ADDR_W'(1));
  assign dn_last   = (ptr == bound);
  assign dump_last = (ptr == ADDR_W'(occ - CNT_W'(1)));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (plan.work)
            W_SHIFT_UP: state_next = S_SHIFT_UP;
            W_SHIFT_DN: state_next = S_SHIFT_DN;
            W_DUMP:     state_next = S_DUMP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SHIFT_UP: if (up_last) state_next = S_PLACE;
      S_PLACE:    state_next = S_IDLE;
      S_SHIFT_DN: if (dn_last) state_next = S_IDLE;
      S_DUMP:     if (out_free && dump_last) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = ptr;
    wdata    = rdata;
    raddr    = ptr;
    load     = 1'b0;
    rsp_next = '0;
    rsp_next.status = ST_OK;
    case (state)
      S_IDLE: begin
        raddr = plan.raddr;
        if (accept) begin
          if (plan.work == W_PLACE) begin
            we    = 1'b1;
            waddr = plan.bound;
            wdata = to_word(req.value);
          end
          if (plan.work != W_DUMP) begin
            load            = 1'b1;
            rsp_next.status = plan.status;
            rsp_next.length = 6'(plan.count);
            rsp_next.last   = 1'b1;
          end
        end
      end
      S_SHIFT_UP: begin
        we    = 1'b1;
        raddr = up_last ? ptr : ptr - ADDR_W'(2);
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = bound;
        wdata = hold;
      end
      S_SHIFT_DN: begin
        we    = 1'b1;
        raddr = dn_last ? ptr : ptr + ADDR_W'(2);
      end
      S_DUMP: begin
        // re-read the same entry while the output register is full
        raddr = (out_free && !dump_last) ? ptr + ADDR_W'(1) : ptr;
        if (out_free) begin
          load             = 1'b1;
          rsp_next.element = to_element(rdata);
          rsp_next.length  = 6'(occ);
          rsp_next.last    = dump_last;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        occ <= plan.count;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
    if (accept) begin
      ptr   <= plan.start;
      bound <= plan.bound;
      hold  <= to_word(req.value);
    end else begin
      case (state)
        S_SHIFT_UP: ptr <= ptr - ADDR_W'(1);
        S_SHIFT_DN: if (!dn_last) ptr <= ptr + ADDR_W'(1);
        S_DUMP:     if (out_free && !dump_last) ptr <= ptr + ADDR_W'(1);
        default:    ptr <= ptr;
      endcase
    end
  end

endmodule

// ----- bench/list_result_checker.sv -----
// Watches both channels of the ordered list, predicts every result and compares it.
module list_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  plo_pkg::req_t req,
  input  logic          req_valid,
  input  logic          req_stall,
  input  plo_pkg::rsp_t rsp,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  output int            errors,
  output int            pending
);
  import plo_pkg::*;

  logic [31:0] held_words[$];
  rsp_t        awaited_rsps[$];
  int          mismatches = 0;
  int          awaited_cnt = 0;

  assign errors  = mismatches;
  assign pending = awaited_cnt;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t list_result_checker: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic rsp_t make_rsp(status_t st, logic [31:0] elem, int len, bit fin);
    rsp_t r;
    r.status  = st;
    r.element = elem;
    r.length  = 6'(len);
    r.last    = fin;
    return r;
  endfunction

  // Append one result at the tail of the awaited list.
  function automatic void await_rsp(rsp_t r);
    awaited_rsps.insert(awaited_rsps.size(), r);
  endfunction

  // Apply one request to the shadow list and queue the results it causes.
  function automatic void apply_request(req_t c);
    status_t     st;
    int unsigned pos;
    int          n;
    st  = ST_OK;
    pos = c.position;
    n   = held_words.size();
    case (c.opcode)
      OP_PUSH_FRONT: begin
        if (n >= CAPACITY) st = ST_FULL;
        else held_words.insert(0, c.value);
      end
      OP_PUSH_BACK: begin
        if (n >= CAPACITY) st = ST_FULL;
        else held_words.insert(n, c.value);
      end
      OP_INSERT: begin
        if (pos == 0 || pos > n + 1) st = ST_BADPOS;
        else if (n >= CAPACITY) st = ST_FULL;
        else held_words.insert(pos - 1, c.value);
      end
      OP_POP_FRONT: begin
        if (n == 0) st = ST_EMPTY;
        else held_words.delete(0);
      end
      OP_POP_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else held_words.delete(n - 1);
      end
      OP_REMOVE: begin
        if (n == 0) st = ST_EMPTY;
        else if (pos == 0 || pos > n) st = ST_BADPOS;
        else held_words.delete(pos - 1);
      end
      OP_CLEAR: begin
        held_words.delete();
      end
      OP_DUMP: begin
        if (n == 0) begin
          await_rsp(make_rsp(ST_EMPTY, 32'd0, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            await_rsp(make_rsp(ST_OK, held_words[i], n, i == n - 1));
        end
        return;
      end
      default: ;
    endcase
    await_rsp(make_rsp(st, 32'd0, held_words.size(), 1'b1));
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      held_words.delete();
      awaited_rsps.delete();
    end else begin
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch("result with nothing awaited, length", 32'(rsp.length), 32'd0);
        end else begin
          want = awaited_rsps[0];
          awaited_rsps.delete(0);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.element !== want.element)
            report_mismatch("element", rsp.element, want.element);
          if (rsp.length !== want.length)
            report_mismatch("length", 32'(rsp.length), 32'(want.length));
          if (rsp.last !== want.last)
            report_mismatch("last", 32'(rsp.last), 32'(want.last));
        end
      end
    end
    awaited_cnt <= awaited_rsps.size();
  end

endmodule

// ----- bench/tb_positional_ordered_list.sv -----
// Stimulus and verdict for the positional ordered list, checked by list_result_checker.
module tb_positional_ordered_list;
  import plo_pkg::*;

  localparam int LONG_HOLD = 120;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  req_t  req = '0;
  logic  req_valid = 1'b0;
  logic  req_stall;
  rsp_t  rsp;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  int    errors;
  int    pending;

  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  bit    hold_ask = 1'b0;
  int    occ = 0;
  bit    grow = 1'b1;

  positional_ordered_list DUT (clk, rst, req, req_valid, req_stall, rsp, rsp_valid, rsp_stall);

  list_result_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb_positional_ordered_list: done, errors");
    $finish;
  end

  // Receiver: random stall, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_ask = 1'b0;
      end
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Send one request and track the list length for position choices.
  task automatic issue(opcode_t op, logic [31:0] v, logic [5:0] p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req.opcode   <= op;
    req.value    <= v;
    req.position <= p;
    req_valid    <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (occ < CAPACITY) occ++;
      OP_INSERT: if (p != 0 && p <= occ + 1 && occ < CAPACITY) occ++;
      OP_POP_FRONT, OP_POP_BACK: if (occ > 0) occ--;
      OP_REMOVE: if (occ > 0 && p != 0 && p <= occ) occ--;
      OP_CLEAR: occ = 0;
      default: ;
    endcase
  endtask

  // Hold off the sender until every awaited result has come.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_request();
    opcode_t     op;
    logic [31:0] v;
    logic [5:0]  p;
    int          roll;
    int          add_pct;
    if (occ == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
    if (occ == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
    add_pct = grow ? 70 : 30;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      op = OP_DUMP;
    end else if (!grow && roll < 8) begin
      op = OP_CLEAR;
    end else if ($urandom_range(0, 99) < add_pct) begin
      case ($urandom_range(0, 2))
        0: op = OP_PUSH_FRONT;
        1: op = OP_PUSH_BACK;
        default: op = OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: op = OP_POP_FRONT;
        1: op = OP_POP_BACK;
        default: op = OP_REMOVE;
      endcase
    end
    v = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end
    if ($urandom_range(0, 99) < 15) p = 6'($urandom_range(0, 33));
    else if (op == OP_INSERT) p = 6'($urandom_range(1, occ + 1));
    else p = 6'($urandom_range(1, (occ > 0) ? occ : 1));
    issue(op, v, p);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 21;
    rx_idle_pct = 57;
    // Errors on an empty list, then build, edit at the ends and middle, dump, clear and dump again.
    issue(OP_DUMP, 32'd0, 6'd0);
    issue(OP_POP_FRONT, 32'd0, 6'd0);
    issue(OP_POP_BACK, 32'd0, 6'd0);
    issue(OP_REMOVE, 32'd0, 6'd1);
    issue(OP_REMOVE, 32'd0, 6'd0);
    issue(OP_INSERT, 32'd1, 6'd0);
    issue(OP_INSERT, 32'd2, 6'd2);
    issue(OP_INSERT, 32'h8000_0000, 6'd1);
    issue(OP_PUSH_FRONT, 32'h7fff_ffff, 6'd0);
    issue(OP_PUSH_BACK, 32'h0000_0000, 6'd0);
    issue(OP_PUSH_BACK, 32'hffff_ffff, 6'd0);
    issue(OP_INSERT, 32'h0000_0005, 6'd5);
    issue(OP_INSERT, 32'ha5a5_a5a5, 6'd3);
    issue(OP_INSERT, 32'h5a5a_5a5a, 6'd33);
    issue(OP_REMOVE, 32'd0, 6'd0);
    issue(OP_REMOVE, 32'd0, 6'd7);
    issue(OP_REMOVE, 32'd0, 6'd3);
    issue(OP_REMOVE, 32'd0, 6'd5);
    issue(OP_POP_FRONT, 32'd0, 6'd0);
    issue(OP_POP_BACK, 32'd0, 6'd0);
    issue(OP_DUMP, 32'd0, 6'd0);
    issue(OP_CLEAR, 32'd0, 6'd0);
    issue(OP_DUMP, 32'd0, 6'd0);
    repeat (75) random_request();
    drain_results();

    tx_idle_pct = 57;
    rx_idle_pct = 21;
    repeat (75) random_request();
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_ask = 1'b1;
    repeat (80) random_request();
    drain_results();
    repeat (40) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb_positional_ordered_list: done, clean");
    end else begin
      $display("tb_positional_ordered_list: done, errors");
    end
    $finish;
  end

endmodule
